// ===== src/rsm_pkg.sv =====
// shared types, constants and layout codes of the raid sector mapper
package rsm_pkg;

    // widths of the datapath
    localparam int SECTOR_W = 48;
    localparam int REM_W    = 17;
    localparam int DISK_W   = 9;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 2;
    localparam int MAX_DISKS = 256;

    // layout codes
    localparam logic [MODE_W-1:0] MODE_RAID0  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAID1  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RAID01 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RAID4  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RAID5  = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DISKS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CHUNK = 2'd2;

    // one request travelling down the divider chains
    typedef struct packed {
        logic                vld;
        logic [MODE_W-1:0]   mode;
        logic [SECTOR_W-1:0] num;
        logic [REM_W-1:0]    rem;
        logic [REM_W-1:0]    div;
        logic [SECTOR_W-1:0] qb;
        logic [REM_W-1:0]    r1;
        logic [REM_W-1:0]    rb;
    } rsm_item_t;

endpackage

// ===== src/rsm_div_cell.sv =====
// one restoring division step: one quotient bit per cell
module rsm_div_cell
    import rsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  rsm_item_t item_in,
    output rsm_item_t item_out
);

    rsm_item_t              item_reg;
    rsm_item_t              item_next;
    logic                   vld_reg;
    logic [REM_W:0]         trial;
    logic                   qbit;

    // shift the next dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        item_next = item_in;
        trial     = {item_in.rem, item_in.num[SECTOR_W-1]};
        qbit      = (trial >= {1'b0, item_in.div});
        if (qbit)
        begin
            item_next.rem = REM_W'(trial - {1'b0, item_in.div});
        end
        else
        begin
            item_next.rem = trial[REM_W-1:0];
        end
        item_next.num = {item_in.num[SECTOR_W-2:0], qbit};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= item_next.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    // payload with the reset valid flag
    always_comb
    begin
        item_out     = item_reg;
        item_out.vld = vld_reg;
    end

endmodule

// ===== src/rsm_div_chain.sv =====
// row of division cells giving quotient and remainder of a full sector word
module rsm_div_chain
    import rsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  rsm_item_t item_in,
    output rsm_item_t item_out
);

    rsm_item_t link [SECTOR_W+1];

    assign link[0] = item_in;

    // one cell per dividend bit, msb first
    for (genvar i = 0; i < SECTOR_W; i++)
    begin : g_cell
        rsm_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .item_in  (link[i]),
            .item_out (link[i+1])
        );
    end

    assign item_out = link[SECTOR_W];

endmodule

// ===== src/rsm_finish.sv =====
// per-layout result assembly and output register
module rsm_finish
    import rsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rsm_item_t           item_in,
    input  logic [DISK_W-1:0]   d_eff,
    input  logic [REM_W-1:0]    c_eff,
    output logic                out_vld,
    output logic [7:0]          disk,
    output logic [SECTOR_W-1:0] row,
    output logic [DISK_W-1:0]   second,
    output logic                has
);

    logic                      f_vld_reg;
    logic [SECTOR_W-1:0]       f_prod_reg;
    logic [REM_W-1:0]          f_add_reg;
    logic [7:0]                f_disk_reg;
    logic [DISK_W-1:0]         f_second_reg;
    logic                      f_has_reg;
    logic                      f_vld_next;
    logic [REM_W-1:0]          mult;
    logic [SECTOR_W+REM_W-1:0] prod_full;
    logic [REM_W-1:0]          add_next;
    logic [DISK_W-1:0]         disk_next;
    logic [DISK_W-1:0]         second_next;
    logic                      has_next;
    logic [DISK_W:0]           t;
    logic [DISK_W-1:0]         parity;
    logic [DISK_W-1:0]         half;
    logic                      out_vld_reg;
    logic [7:0]                disk_reg;
    logic [SECTOR_W-1:0]       row_reg;
    logic [DISK_W-1:0]         second_reg;
    logic                      has_reg;

    // per-layout selection of disks and row factor
    always_comb
    begin
        f_vld_next  = item_in.vld;
        mult        = REM_W'(1);
        add_next    = '0;
        disk_next   = item_in.rb[DISK_W-1:0];
        second_next = '0;
        has_next    = 1'b1;
        t           = '0;
        parity      = '0;
        half        = d_eff >> 1;
        unique case (item_in.mode)
            MODE_RAID0:
            begin
                mult     = c_eff;
                add_next = item_in.r1;
                has_next = 1'b0;
            end
            MODE_RAID1:
            begin
                mult = REM_W'(2);
                t    = {item_in.rb[DISK_W-1:0], 1'b0};
                if (t >= {1'b0, d_eff})
                begin
                    t        = t - {1'b0, d_eff};
                    add_next = REM_W'(1);
                end
                disk_next   = t[DISK_W-1:0];
                second_next = DISK_W'(t + 1'b1);
            end
            MODE_RAID01:
            begin
                second_next = d_eff - half + item_in.rb[DISK_W-1:0];
            end
            MODE_RAID4:
            begin
                mult        = c_eff;
                add_next    = item_in.r1;
                second_next = d_eff - 1'b1;
            end
            MODE_RAID5:
            begin
                parity = d_eff - 1'b1 - item_in.rem[DISK_W-1:0];
                t      = {1'b0, parity} + 1'b1 + {1'b0, item_in.rb[DISK_W-1:0]};
                if (t >= {1'b0, d_eff})
                begin
                    t = t - {1'b0, d_eff};
                end
                disk_next   = t[DISK_W-1:0];
                second_next = parity;
            end
            default:
            begin
                f_vld_next = 1'b0;
            end
        endcase
    end

    assign prod_full = item_in.qb * mult;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_prod_reg   <= prod_full[SECTOR_W-1:0];
            f_add_reg    <= add_next;
            f_disk_reg   <= disk_next[7:0];
            f_second_reg <= second_next;
            f_has_reg    <= has_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disk_reg   <= f_disk_reg;
            row_reg    <= f_prod_reg + SECTOR_W'(f_add_reg);
            second_reg <= f_second_reg;
            has_reg    <= f_has_reg;
        end
    end

    assign out_vld = out_vld_reg;
    assign disk    = disk_reg;
    assign row     = row_reg;
    assign second  = second_reg;
    assign has     = has_reg;

endmodule

// ===== src/raid_sector_mapper_unit.sv =====
// top level of the raid sector mapper: config registers, three divider chains, result stage
//
//   channel   direction  handshake              payload
//   in        request    in_valid / in_stall    sector_number
//   out       result     out_valid / out_stall  data_disk, stripe_row, second_disk, has_second
//   cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle while no result is held; the pipeline is three
// chains of one-bit division cells (sector / chunk, / columns, mod disks)
// followed by a multiply stage and the output register.
// reset clears valid flags and sets raid0, two disks, chunk of one.
// a stalled result holds the whole pipeline; in_stall follows it at once.
module raid_sector_mapper_unit
    import rsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SECTOR_W-1:0] sector_number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          data_disk,
    output logic [SECTOR_W-1:0] stripe_row,
    output logic [DISK_W-1:0]   second_disk,
    output logic                has_second,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [REM_W-1:0]    cfg_data
);

    logic [MODE_W-1:0] raid_mode_reg;
    logic [DISK_W-1:0] disk_count_reg;
    logic [REM_W-1:0]  chunk_size_reg;
    logic [DISK_W-1:0] d_eff;
    logic [REM_W-1:0]  c_eff;
    logic              adv;
    rsm_item_t         c1_in;
    rsm_item_t         c1_out;
    rsm_item_t         c2_in;
    rsm_item_t         c2_out;
    rsm_item_t         c3_in;
    rsm_item_t         c3_out;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raid_mode_reg  <= MODE_RAID0;
            disk_count_reg <= DISK_W'(2);
            chunk_size_reg <= REM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:  raid_mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_DISKS: disk_count_reg <= cfg_data[DISK_W-1:0];
                CFG_CHUNK: chunk_size_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // clamped disk count and chunk size
    always_comb
    begin
        d_eff = disk_count_reg;
        if (disk_count_reg < DISK_W'(2))
        begin
            d_eff = DISK_W'(2);
        end
        else if (disk_count_reg > DISK_W'(MAX_DISKS))
        begin
            d_eff = DISK_W'(MAX_DISKS);
        end
        c_eff = (chunk_size_reg == '0) ? REM_W'(1) : chunk_size_reg;
    end

    // pipeline moves unless a result is held
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // first chain: sector / chunk for the striped layouts
    always_comb
    begin
        c1_in      = '0;
        c1_in.vld  = in_valid;
        c1_in.mode = raid_mode_reg;
        c1_in.num  = sector_number;
        c1_in.div  = ((raid_mode_reg == MODE_RAID0) || (raid_mode_reg == MODE_RAID4))
                     ? c_eff : REM_W'(1);
    end

    rsm_div_chain u_chain1
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .item_in  (c1_in),
        .item_out (c1_out)
    );

    // second chain: divide by the column count of the layout
    always_comb
    begin
        c2_in     = c1_out;
        c2_in.rem = '0;
        c2_in.r1  = c1_out.rem;
        unique case (c1_out.mode)
            MODE_RAID01:            c2_in.div = REM_W'(d_eff >> 1);
            MODE_RAID4, MODE_RAID5: c2_in.div = REM_W'(d_eff - 1'b1);
            default:                c2_in.div = REM_W'(d_eff);
        endcase
    end

    rsm_div_chain u_chain2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .item_in  (c2_in),
        .item_out (c2_out)
    );

    // third chain: row modulo disk count for parity rotation
    always_comb
    begin
        c3_in     = c2_out;
        c3_in.rem = '0;
        c3_in.div = REM_W'(d_eff);
        c3_in.qb  = c2_out.num;
        c3_in.rb  = c2_out.rem;
    end

    rsm_div_chain u_chain3
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .item_in  (c3_in),
        .item_out (c3_out)
    );

    // result assembly
    rsm_finish u_finish
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .item_in (c3_out),
        .d_eff   (d_eff),
        .c_eff   (c_eff),
        .out_vld (out_valid),
        .disk    (data_disk),
        .row     (stripe_row),
        .second  (second_disk),
        .has     (has_second)
    );

    // checks
    a_no_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_second |-> second_disk == '0)
        else $error("second disk set without a second copy");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("held result dropped");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

// ===== tb/tb.sv =====
// testbench of the raid sector mapper: directed and random requests against a behavioural predictor
module tb;
    import rsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SECTOR_W-1:0] sector_number;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          data_disk;
    logic [SECTOR_W-1:0] stripe_row;
    logic [DISK_W-1:0]   second_disk;
    logic                has_second;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [REM_W-1:0]    cfg_data;

    typedef struct packed {
        logic [7:0]          disk;
        logic [SECTOR_W-1:0] row;
        logic [DISK_W-1:0]   second;
        logic                has;
    } location_t;

    localparam int LATENCY   = 3 * 48 + 2;
    localparam int MAX_CYCLE = 2000000;

    // predictor copy of the registers
    logic [MODE_W-1:0] layout_mode;
    logic [8:0]        array_disks;
    logic [16:0]       chunk_sectors;

    location_t locations_due[$];
    int        mismatches;
    int        cycle_count;
    int        burst_left;

    raid_sector_mapper_unit dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // map one sector as the configured layout places it
    function automatic location_t map_sector(logic [SECTOR_W-1:0] sec);
        location_t  loc;
        logic [63:0] s, d, c, chunk, r, half, parity;
        s = 64'(sec);
        d = 64'(array_disks);
        if (d < 2) d = 2;
        if (d > MAX_DISKS) d = MAX_DISKS;
        c = (chunk_sectors == 0) ? 64'd1 : 64'(chunk_sectors);
        loc = '0;
        loc.has = 1'b1;
        case (layout_mode)
            MODE_RAID0:
            begin
                chunk = s / c;
                loc.disk = 8'(chunk % d);
                loc.row = SECTOR_W'((chunk / d) * c + s % c);
                loc.has = 1'b0;
            end
            MODE_RAID1:
            begin
                r = s % d;
                loc.disk = 8'((r * 2) % d);
                loc.row = SECTOR_W'((s / d) * 2 + (r * 2) / d);
                loc.second = DISK_W'(((r * 2) % d) + 1);
            end
            MODE_RAID01:
            begin
                half = d / 2;
                loc.disk = 8'(s % half);
                loc.row = SECTOR_W'(s / half);
                loc.second = DISK_W'(d - half + s % half);
            end
            MODE_RAID4:
            begin
                chunk = s / c;
                loc.disk = 8'(chunk % (d - 1));
                loc.row = SECTOR_W'((chunk / (d - 1)) * c + s % c);
                loc.second = DISK_W'(d - 1);
            end
            default:
            begin
                r = s / (d - 1);
                parity = d - 1 - r % d;
                loc.row = SECTOR_W'(r);
                loc.disk = 8'((parity + 1 + s % (d - 1)) % d);
                loc.second = DISK_W'(parity);
            end
        endcase
        return loc;
    endfunction

    // write one register, block idle
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REM_W-1:0] val);
        in_valid  <= 1'b0;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:  layout_mode   = val[MODE_W-1:0];
            CFG_DISKS: array_disks   = val[8:0];
            default:   chunk_sectors = val;
        endcase
        @(negedge clk);
    endtask

    task automatic set_layout(int mode, int disks, int chunk);
        write_reg(CFG_MODE, REM_W'(mode));
        write_reg(CFG_DISKS, REM_W'(disks));
        write_reg(CFG_CHUNK, REM_W'(chunk));
    endtask

    // send one request with burst gaps; the next caller drops valid
    task automatic send_sector(logic [SECTOR_W-1:0] sec);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sector_number <= sec;
        in_valid      <= 1'b1;
        if (layout_mode <= MODE_RAID5)
            locations_due.push_back(map_sector(sec));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // wait for the pipeline to drain
    task automatic drain;
        in_valid <= 1'b0;
        while (locations_due.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [SECTOR_W-1:0] rand_sector();
        case ($urandom_range(0, 3))
            0: return SECTOR_W'($urandom_range(0, 1000));
            1: return SECTOR_W'({$urandom, $urandom} >> $urandom_range(0, 47));
            default: return SECTOR_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic test_directed;
        logic [SECTOR_W-1:0] edges [4];
        edges = '{'0, 48'd1, {SECTOR_W{1'b1}}, 48'h8000_0000_0000};
        // every layout on extremes, odd disks in mirrored modes
        for (int m = 0; m <= 4; m++)
        begin
            set_layout(m, (m == 1) ? 7 : 5, (m == 3) ? 65536 : 3);
            foreach (edges[i]) send_sector(edges[i]);
            drain();
        end
        // disk count and chunk clamping
        set_layout(MODE_RAID0, 0, 0);
        send_sector(48'd9);
        send_sector({SECTOR_W{1'b1}});
        drain();
        set_layout(MODE_RAID5, 511, 65535);
        send_sector({SECTOR_W{1'b1}});
        send_sector(48'd1234567);
        drain();
        // unknown layouts give nothing
        for (int m = 5; m <= 7; m++)
        begin
            write_reg(CFG_MODE, REM_W'(m));
            send_sector(48'd77);
            drain();
        end
    endtask

    task automatic test_random;
        for (int p = 0; p < 16; p++)
        begin
            set_layout($urandom_range(0, 4), (p % 4 == 0) ? 256 : $urandom_range(2, 20),
                       (p % 5 == 0) ? 131071 : $urandom_range(1, 64));
            repeat (50) send_sector(rand_sector());
            drain();
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (cycle_count % 2000 < 400)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // result check
    always @(posedge clk)
    begin
        location_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (locations_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result disk %0d row %0d", data_disk, stripe_row);
            end
            else
            begin
                want = locations_due.pop_front();
                if (want != {data_disk, stripe_row, second_disk, has_second})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.disk, want.row, want.second, want.has,
                                 data_disk, stripe_row, second_disk, has_second);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sector_number = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        layout_mode = MODE_RAID0;
        array_disks = 9'd2;
        chunk_sectors = 17'd1;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        if (mismatches == 0 && locations_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
